[rtl/core/sle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sorted list engine
// Request and result item formats, request and status codes, cell controls.
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 6;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_OUT_RANGE = 2'd2,
        STATUS_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        logic [1:0]                 status;
        logic [COUNT_OUT_W-1:0]     entry_count;
    } t_out_item;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                       do_ins;
        logic                       do_rem;
        logic signed [VALUE_W-1:0]  value;
        logic [POS_W-1:0]           position;
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/core/sle_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sle_cell: one slot of the sorted chain
// Holds one entry, compares it to the broadcast value and on insert takes its left
// neighbor's entry or the value, on remove its right neighbor's entry, else keeps its own.
// ---------------------------------------------------------------------------
module sle_cell #(
    parameter int IDX     = 0,
    parameter int COUNT_W = 7
) (
    input  wire                                i_clk,
    input  wire sle_pkg::t_cell_ctl            i_ctl,
    input  wire [COUNT_W-1:0]                  i_count,
    input  wire signed [sle_pkg::VALUE_W-1:0]  i_left_entry,
    input  wire                                i_left_past,
    input  wire signed [sle_pkg::VALUE_W-1:0]  i_right_entry,
    output logic signed [sle_pkg::VALUE_W-1:0] o_entry,
    output logic                               o_past,
    output logic                               o_match,
    output logic [sle_pkg::VALUE_W-1:0]        o_read
);

    logic signed [sle_pkg::VALUE_W-1:0] r_entry;
    logic signed [sle_pkg::VALUE_W-1:0] n_entry;
    logic                               live;
    logic                               at_or_above;

    assign live        = 32'(IDX) < 32'(i_count);
    // Past the insert point: empty slot or entry strictly above the value.
    assign o_past      = !live || (r_entry > i_ctl.value);
    assign o_match     = live && (r_entry == i_ctl.value);
    assign at_or_above = live && (r_entry >= i_ctl.value);
    assign o_read      = (32'(i_ctl.position) == 32'(IDX)) ? r_entry : '0;
    assign o_entry     = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_ins) begin
            // Shift right behind the insert point, drop the value at it.
            if (i_left_past) begin
                n_entry = i_left_entry;
            end else if (o_past) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.do_rem && at_or_above) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
`default_nettype wire

[rtl/core/sle_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sle_chain: row of sorted cells
// Links the cells to their neighbors and gathers the match and read lines.
// ---------------------------------------------------------------------------
module sle_chain #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF,
    parameter int COUNT_W  = $clog2(CAPACITY + 1)
) (
    input  wire                                i_clk,
    input  wire sle_pkg::t_cell_ctl            i_ctl,
    input  wire [COUNT_W-1:0]                  i_count,
    output logic                               o_found,
    output logic [sle_pkg::VALUE_W-1:0]        o_read_data
);

    logic signed [sle_pkg::VALUE_W-1:0] entry [CAPACITY];
    logic                               past  [CAPACITY];
    logic [CAPACITY-1:0]                match;
    logic [sle_pkg::VALUE_W-1:0]        rd    [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [sle_pkg::VALUE_W-1:0] left_entry;
        logic                               left_past;
        logic signed [sle_pkg::VALUE_W-1:0] right_entry;

        if (g == 0) begin : g_first
            assign left_entry = entry[g];
            assign left_past  = 1'b0;
        end else begin : g_mid
            assign left_entry = entry[g-1];
            assign left_past  = past[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = entry[g];
        end else begin : g_inner
            assign right_entry = entry[g+1];
        end

        sle_cell #(
            .IDX     (g),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (i_ctl),
            .i_count       (i_count),
            .i_left_entry  (left_entry),
            .i_left_past   (left_past),
            .i_right_entry (right_entry),
            .o_entry       (entry[g]),
            .o_past        (past[g]),
            .o_match       (match[g]),
            .o_read        (rd[g])
        );
    end

    assign o_found = |match;

    // Only the cell at the requested position drives nonzero data.
    always_comb begin
        o_read_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_read_data = o_read_data | rd[k];
        end
    end

endmodule
`default_nettype wire

[rtl/core/sorted_list_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_list_engine: bounded sorted multiset of signed 32-bit values
// Insert, remove-first-equal and read-by-position on a row of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with payload i_in_item; one
//   result per request leaves on o_out_valid / i_out_ready as o_out_item.
//   Every cell compares its entry to the request value in parallel and
//   shifts toward its neighbor in the same cycle, and the result of a
//   request appears in the output register in the next cycle; throughput
//   1 item per cycle while the receiver keeps taking results.
//   If the receiver stalls, the result holds in the output register and
//   o_in_ready drops until it is taken; no item is lost.
//   Reset empties the store (count zero) and clears the output valid; the
//   block is ready for items once reset is released. Entry contents are
//   not cleared; slots past the count are never read.
// ---------------------------------------------------------------------------
module sorted_list_engine #(
    parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  wire sle_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output sle_pkg::t_out_item      o_out_item
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic [COUNT_W-1:0]          r_count;
    logic [COUNT_W-1:0]          n_count;
    logic                        r_out_valid;
    logic                        n_out_valid;
    sle_pkg::t_out_item          r_out_item;
    sle_pkg::t_out_item          n_out_item;
    sle_pkg::t_cell_ctl          ctl;
    logic                        accept;
    logic                        full;
    logic                        found;
    logic [sle_pkg::VALUE_W-1:0] read_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = r_count == COUNT_W'(CAPACITY);

    sle_chain #(
        .CAPACITY (CAPACITY),
        .COUNT_W  (COUNT_W)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_count     (r_count),
        .o_found     (found),
        .o_read_data (read_data)
    );

    always_comb begin
        ctl.do_ins   = 1'b0;
        ctl.do_rem   = 1'b0;
        ctl.value    = i_in_item.value;
        ctl.position = i_in_item.position;
        n_count      = r_count;
        n_out_item.read_value = '0;
        n_out_item.status     = sle_pkg::STATUS_OK;
        case (i_in_item.req_type)
            sle_pkg::REQ_INSERT: begin
                if (full) begin
                    n_out_item.status = sle_pkg::STATUS_FULL;
                end else begin
                    ctl.do_ins = accept;
                    n_count    = r_count + COUNT_W'(1);
                end
            end
            sle_pkg::REQ_REMOVE: begin
                if (found) begin
                    ctl.do_rem = accept;
                    n_count    = r_count - COUNT_W'(1);
                end else begin
                    n_out_item.status = sle_pkg::STATUS_NOT_FOUND;
                end
            end
            sle_pkg::REQ_READ: begin
                if (32'(i_in_item.position) < 32'(r_count)) begin
                    n_out_item.read_value = read_data;
                end else begin
                    n_out_item.status = sle_pkg::STATUS_OUT_RANGE;
                end
            end
            default: begin
                // Unused selector: leave the store alone, report ok.
            end
        endcase
        n_out_item.entry_count = sle_pkg::COUNT_OUT_W'(n_count);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire
